// ----- design/line_counting_char_fifo_macros.svh -----
// ----------------------------------------------------------------------------
// line_counting_char_fifo_macros
// assertion helpers shared by the line counting fifo
// ----------------------------------------------------------------------------
`ifndef LINE_COUNTING_CHAR_FIFO_MACROS_SVH
`define LINE_COUNTING_CHAR_FIFO_MACROS_SVH

// same-cycle implication, held off during reset
`define LCCF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lccf assertion failed");

// next-cycle implication, held off during reset
`define LCCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lccf assertion failed");

`endif

// ----- design/lccf_pkg.sv -----
// ----------------------------------------------------------------------------
// lccf_pkg
// word types, action and status codes of the line counting fifo
// ----------------------------------------------------------------------------
package lccf_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_LINE  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] STS_DONE     = 2'd0;
  localparam logic [1:0] STS_EMPTY    = 2'd1;
  localparam logic [1:0] STS_DROPPED  = 2'd2;
  localparam logic [1:0] STS_FILTERED = 2'd3;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] IGNORED_RST  = 8'h3F;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       last_of_line;
    logic [1:0] status;
    logic [5:0] fill_level;
    logic [5:0] lines_held;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_LINE
  } state_t;

endpackage

// ----- design/lccf_ram.sv -----
// ----------------------------------------------------------------------------
// lccf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/line_counting_char_fifo.sv -----
// ----------------------------------------------------------------------------
// line_counting_char_fifo: circular byte fifo with a running line count
// write, read and clear each give one result word, a line read one word per byte;
// the head byte is read ahead from the ram, so the ram read port sets no stall
// result appears in the output register the cycle after acceptance
// synchronous active-low reset empties the buffer, ignored byte returns to '?'
// ----------------------------------------------------------------------------
`include "line_counting_char_fifo_macros.svh"

module line_counting_char_fifo #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lccf_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lccf_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data
);

  import lccf_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W  = $clog2(BUFFER_DEPTH);
  localparam int EXT_W  = (CNT_W > 6) ? CNT_W : 6;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(BUFFER_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(BUFFER_DEPTH);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  lc_r, lc_nxt;
  logic [7:0]        ign_r;
  logic              byp_r;
  logic [7:0]        byp_data_r;
  logic              out_valid_r;
  out_word_t         out_r, res;

  logic              in_acc, out_free, out_load, we, pop, line_rd;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        ram_rdata, head_byte;
  logic [CNT_W-1:0]  fill_cur, fill_new;
  logic [EXT_W-1:0]  fill_ext, lc_ext;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    ptr_inc = (p == LAST_ADDR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] fill_of(input logic [ADDR_W-1:0] h,
                                               input logic [ADDR_W-1:0] t);
    logic [ADDR_W:0] diff;
    diff = (t >= h) ? ({1'b0, t} - {1'b0, h}) : ({1'b0, t} + DEPTH_EXT - {1'b0, h});
    fill_of = CNT_W'(diff);
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !rst_n || (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign fill_cur = fill_of(head_r, tail_r);

  // head byte, forwarded when the ram was written at the address being read
  assign head_byte = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    lc_nxt    = lc_r;
    we        = 1'b0;
    pop       = 1'b0;
    line_rd   = 1'b0;
    out_load  = 1'b0;
    res       = '0;
    res.last_of_line = 1'b1;
    res.status       = STS_DONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          unique case (in_word.action)
            ACT_WRITE: begin
              if (in_word.data_in == ign_r) begin
                res.status = STS_FILTERED;
              end else if (fill_cur == FULL_CNT) begin
                res.status = STS_DROPPED;
              end else begin
                we       = 1'b1;
                tail_nxt = ptr_inc(tail_r);
                if (in_word.data_in == NEWLINE_BYTE) begin
                  lc_nxt = lc_r + 1'b1;
                end
              end
            end
            ACT_READ: begin
              if (fill_cur == '0) begin
                res.status = STS_EMPTY;
              end else begin
                pop = 1'b1;
              end
            end
            ACT_LINE: begin
              if (lc_r == '0) begin
                res.status = STS_EMPTY;
              end else begin
                pop     = 1'b1;
                line_rd = 1'b1;
              end
            end
            ACT_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
              lc_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_LINE: begin
        if (out_free) begin
          out_load = 1'b1;
          pop      = 1'b1;
          line_rd  = 1'b1;
        end
      end
      default: ;
    endcase

    if (pop) begin
      head_nxt       = ptr_inc(head_r);
      res.data_out   = head_byte;
      res.data_valid = 1'b1;
      if (head_byte == NEWLINE_BYTE && lc_nxt != '0) begin
        lc_nxt = lc_nxt - 1'b1;
      end
      if (line_rd) begin
        res.last_of_line = (head_byte == NEWLINE_BYTE);
        if (head_byte == NEWLINE_BYTE || head_nxt == tail_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_LINE;
        end
      end
    end

    fill_new       = fill_of(head_nxt, tail_nxt);
    fill_ext       = EXT_W'(fill_new);
    lc_ext         = EXT_W'(lc_nxt);
    res.fill_level = fill_ext[5:0];
    res.lines_held = lc_ext[5:0];
  end

  assign raddr = rst_n ? head_nxt : '0;

  lccf_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (tail_r),
    .wdata (in_word.data_in),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      lc_r        <= '0;
      ign_r       <= IGNORED_RST;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      lc_r    <= lc_nxt;
      byp_r   <= we && (tail_r == raddr);
      if (cfg_we) begin
        ign_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= in_word.data_in;
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // lines held never exceed bytes held
  `LCCF_ASSERT_NOW(a_lines_in_fill, clk, rst_n, 1'b1, lc_r <= fill_cur)
  // a line read in progress still has its newline ahead
  `LCCF_ASSERT_NOW(a_line_has_nl, clk, rst_n, state_r == ST_LINE, lc_r != '0)
  // pointers move only together with a result
  `LCCF_ASSERT_NEXT(a_ptr_hold, clk, rst_n, !out_load, $stable(head_r) && $stable(tail_r))

endmodule

// ----- tb/sv/tb_line_counting_char_fifo.sv -----
// ----------------------------------------------------------------------------
// tb_line_counting_char_fifo
// self-checking bench for the line counting byte fifo: a software copy of
// the buffer predicts every result word, random idle on both sides, a long
// output hold to back the fifo up, and several ignored-byte settings
// ----------------------------------------------------------------------------
module tb_line_counting_char_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import lccf_pkg::*;

  localparam int DEPTH       = 64;
  localparam int HOLD_CYCLES = 200;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_we;
  logic [7:0] cfg_data;

  // software copy of the buffer
  logic [7:0] byte_mem [DEPTH];
  int         head_idx;
  int         tail_idx;
  int         line_total;
  logic [7:0] ignored_val;

  out_word_t  awaited_words [$];
  out_word_t  oldest_word;
  int         fail_count;
  int         busy_pct;
  int         stall_len;
  bit         hold_req;

  line_counting_char_fifo #(
    .BUFFER_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int fifo_fill();
    return (tail_idx + DEPTH - head_idx) % DEPTH;
  endfunction

  function automatic void queue_result(input logic [7:0] dat, input logic vld,
                                       input logic last, input logic [1:0] sts);
    out_word_t w;
    w.data_out     = dat;
    w.data_valid   = vld;
    w.last_of_line = last;
    w.status       = sts;
    w.fill_level   = 6'(fifo_fill());
    w.lines_held   = 6'(line_total);
    awaited_words.push_back(w);
  endfunction

  function automatic logic [7:0] pop_byte();
    logic [7:0] b;
    b = byte_mem[head_idx];
    head_idx = (head_idx + 1) % DEPTH;
    if (b == NEWLINE_BYTE && line_total > 0) line_total--;
    return b;
  endfunction

  function automatic void apply_action(input logic [1:0] act, input logic [7:0] dat);
    int         left;
    logic [7:0] b;
    logic       more;
    case (act)
      ACT_WRITE: begin
        if (dat == ignored_val) begin
          queue_result(8'h00, 1'b0, 1'b1, STS_FILTERED);
        end else if (fifo_fill() >= DEPTH - 1) begin
          queue_result(8'h00, 1'b0, 1'b1, STS_DROPPED);
        end else begin
          byte_mem[tail_idx] = dat;
          tail_idx = (tail_idx + 1) % DEPTH;
          if (dat == NEWLINE_BYTE) line_total++;
          queue_result(8'h00, 1'b0, 1'b1, STS_DONE);
        end
      end
      ACT_READ: begin
        if (fifo_fill() == 0) begin
          queue_result(8'h00, 1'b0, 1'b1, STS_EMPTY);
        end else begin
          b = pop_byte();
          queue_result(b, 1'b1, 1'b1, STS_DONE);
        end
      end
      ACT_LINE: begin
        if (line_total == 0) begin
          queue_result(8'h00, 1'b0, 1'b1, STS_EMPTY);
        end else begin
          left = fifo_fill();
          more = 1'b1;
          while (more && left > 0) begin
            b = pop_byte();
            left--;
            if (b == NEWLINE_BYTE || left == 0) more = 1'b0;
            queue_result(b, 1'b1, b == NEWLINE_BYTE, STS_DONE);
          end
        end
      end
      default: begin
        head_idx   = 0;
        tail_idx   = 0;
        line_total = 0;
        queue_result(8'h00, 1'b0, 1'b1, STS_DONE);
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (busy_pct == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(10, 40);
    if (r < busy_pct) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic void check_field(input string label, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: result word expected none actual %p", $time, out_word);
        fail_count++;
      end else begin
        oldest_word = awaited_words.pop_front();
        check_field("data_out", oldest_word.data_out, out_word.data_out);
        check_field("data_valid", 8'(oldest_word.data_valid), 8'(out_word.data_valid));
        check_field("last_of_line", 8'(oldest_word.last_of_line),
                    8'(out_word.last_of_line));
        check_field("status", 8'(oldest_word.status), 8'(out_word.status));
        check_field("fill_level", 8'(oldest_word.fill_level), 8'(out_word.fill_level));
        check_field("lines_held", 8'(oldest_word.lines_held), 8'(out_word.lines_held));
      end
    end
  end

  // receiver stall, with a long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [7:0] dat);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {act, dat};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_action(act, dat);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_ignored(input logic [7:0] val);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    ignored_val = val;
  endtask

  task automatic test_empty_buffer();
    send_word(ACT_READ, 8'h00);
    send_word(ACT_LINE, 8'hFF);
  endtask

  task automatic test_write_read();
    send_word(ACT_WRITE, 8'h00);
    send_word(ACT_WRITE, 8'hFF);
    send_word(ACT_WRITE, IGNORED_RST);
    send_word(ACT_READ, 8'h00);
    send_word(ACT_READ, 8'h00);
    send_word(ACT_READ, 8'h00);
  endtask

  task automatic test_line_read();
    send_word(ACT_WRITE, "a");
    send_word(ACT_WRITE, "b");
    send_word(ACT_WRITE, NEWLINE_BYTE);
    send_word(ACT_WRITE, "c");
    send_word(ACT_WRITE, NEWLINE_BYTE);
    send_word(ACT_WRITE, "d");
    send_word(ACT_LINE, 8'h00);
    send_word(ACT_LINE, 8'h00);
    // partial line left behind
    send_word(ACT_LINE, 8'h00);
    send_word(ACT_READ, 8'h00);
    send_word(ACT_WRITE, NEWLINE_BYTE);
    send_word(ACT_READ, 8'h00);
  endtask

  task automatic test_clear();
    send_word(ACT_WRITE, "x");
    send_word(ACT_WRITE, NEWLINE_BYTE);
    send_word(ACT_CLEAR, 8'h55);
    send_word(ACT_READ, 8'h00);
    send_word(ACT_LINE, 8'h00);
  endtask

  task automatic test_ignored_byte();
    set_ignored(8'h00);
    send_word(ACT_WRITE, 8'h00);
    send_word(ACT_WRITE, IGNORED_RST);
    send_word(ACT_READ, 8'h00);
    set_ignored(8'hFF);
    send_word(ACT_WRITE, 8'hFF);
    send_word(ACT_WRITE, 8'h00);
    send_word(ACT_READ, 8'h00);
    set_ignored(NEWLINE_BYTE);
    send_word(ACT_WRITE, NEWLINE_BYTE);
    send_word(ACT_LINE, 8'h00);
    send_word(ACT_CLEAR, 8'h00);
    set_ignored(IGNORED_RST);
  endtask

  task automatic test_full_under_backpressure();
    int i;
    busy_pct = 0;
    send_word(ACT_CLEAR, 8'h00);
    hold_req = 1'b1;
    // 63 bytes fit, the rest are dropped
    for (i = 0; i < 70; i++) begin
      send_word(ACT_WRITE, (i % 8 == 7) ? NEWLINE_BYTE : 8'(8'h41 + i % 8));
    end
    send_word(ACT_WRITE, ignored_val);
    for (i = 0; i < 8; i++) send_word(ACT_LINE, 8'h00);
    for (i = 0; i < 8; i++) send_word(ACT_READ, 8'h00);
  endtask

  task automatic test_random_text();
    int         phase;
    int         sent;
    int         r;
    int         k;
    int         j;
    logic [7:0] ch;
    for (phase = 0; phase < 3; phase++) begin
      set_ignored((phase == 0) ? IGNORED_RST : 8'($urandom_range(0, 255)));
      busy_pct = (phase == 1) ? 0 : 30 + 20 * phase / 2;
      sent = 0;
      while (sent < 30) begin
        r = $urandom_range(0, 99);
        if (fifo_fill() > 50 && r < 55) r = 70;
        if (r < 50) begin
          k = $urandom_range(1, 6);
          for (j = 0; j < k; j++) begin
            ch = 8'($urandom_range(0, 255));
            send_word(ACT_WRITE, ch);
          end
          send_word(ACT_WRITE, NEWLINE_BYTE);
          sent += k + 1;
        end else begin
          if (r < 55) send_word(ACT_WRITE, ignored_val);
          else if (r < 62) send_word(ACT_WRITE, 8'($urandom_range(0, 255)));
          else if (r < 80) send_word(ACT_LINE, 8'($urandom_range(0, 255)));
          else if (r < 96) send_word(ACT_READ, 8'($urandom_range(0, 255)));
          else send_word(ACT_CLEAR, 8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    cfg_we      = 1'b0;
    cfg_data    = 8'h00;
    head_idx    = 0;
    tail_idx    = 0;
    line_total  = 0;
    ignored_val = IGNORED_RST;
    fail_count  = 0;
    busy_pct    = 30;
    hold_req    = 1'b0;
    foreach (byte_mem[i]) byte_mem[i] = 8'h00;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_buffer();
    test_write_read();
    test_line_read();
    test_clear();
    test_ignored_byte();
    test_full_under_backpressure();
    test_random_text();

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
